@@ hdl/bcu_pkg.sv @@
// Shared types and constants for the block cipher unpad checker.
package bcu_pkg;

   localparam int BLOCK_BYTES_DEF = 16;
   localparam int COUNT_BITS_DEF  = 32;
   localparam int DATA_W          = 8;
   localparam int LEN_W           = 32;
   localparam int MODE_W          = 3;

   localparam logic [DATA_W-1:0] ISO_MARK = 8'h80;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_BAD   = 2'd1,
      STATUS_UNSUP = 2'd2
   } status_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_PKCS7 = 3'd0,
      MODE_ANSI  = 3'd1,
      MODE_ISO   = 3'd2,
      MODE_ZERO  = 3'd3,
      MODE_NONE  = 3'd4
   } pad_mode_type;

   typedef struct packed {
      logic [LEN_W-1:0] message_length;
      status_type       status;
   } result_type;

endpackage

@@ hdl/bcu_channels.sv @@
// Valid/ready channel interfaces for message bytes and unpad results.
interface bcu_req_if
   import bcu_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface bcu_rsp_if
   import bcu_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] message_length;
   status_type       status;

   modport source (output valid, output message_length, output status, input ready);
   modport sink   (input valid, input message_length, input status, output ready);
endinterface

@@ hdl/block_cipher_unpad_checker.sv @@
// Top level of the block cipher unpad checker.
// The block takes one message byte per cycle, except while a final byte waits for a free
// output register, and keeps up with a continuous stream otherwise. A byte transfer is
// registered, then folded into the running message state as it leaves that register; on the
// final byte the unpadded length and status land in the result register instead. The update
// of the running counters on every byte sets this rate. A result waiting in the output
// register stalls only the next final byte and the bytes behind it; earlier bytes keep
// flowing. Write the padding mode only while no message is in flight.
module block_cipher_unpad_checker
   import bcu_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   bcu_req_if.sink           req_port,
   bcu_rsp_if.source         rsp_port,
   input  logic              csr_write_en,
   input  logic [MODE_W-1:0] csr_write_data
);

   pad_mode_type      mode_ff;
   logic              s1_valid_ff;
   logic [DATA_W-1:0] s1_byte_ff;
   logic              s1_final_ff;
   logic              out_valid_ff;
   result_type        out_ff;

   logic              out_free;
   logic              s1_step;
   logic              req_take;
   result_type        result;

   assign out_free = !out_valid_ff || rsp_port.ready;
   assign s1_step  = s1_valid_ff && (!s1_final_ff || out_free);
   assign req_port.ready = !s1_valid_ff || s1_step;
   assign req_take = req_port.valid && req_port.ready;

   assign rsp_port.valid          = out_valid_ff;
   assign rsp_port.message_length = out_ff.message_length;
   assign rsp_port.status         = out_ff.status;

   bcu_tracker #(
      .BLOCK_BYTES (BLOCK_BYTES),
      .COUNT_BITS  (COUNT_BITS)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (s1_step),
      .data_byte  (s1_byte_ff),
      .final_byte (s1_final_ff),
      .pad_mode   (mode_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PKCS7;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            mode_ff <= pad_mode_type'(csr_write_data);
         end
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_step) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_step && s1_final_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_port.data_byte;
         s1_final_ff <= req_port.final_byte;
      end
      if (s1_step && s1_final_ff) begin
         out_ff <= result;
      end
   end

endmodule

@@ hdl/bcu_tracker.sv @@
// Running message state and the padding verdict for the byte being retired.
module bcu_tracker
   import bcu_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [DATA_W-1:0] data_byte,
   input  logic              final_byte,
   input  pad_mode_type      pad_mode,
   output result_type        result
);

   localparam int RUN_W = $clog2(BLOCK_BYTES + 1);
   localparam int POS_W = $clog2(BLOCK_BYTES);
   localparam logic [RUN_W-1:0]  RUN_MAX  = RUN_W'(BLOCK_BYTES);
   localparam logic [POS_W-1:0]  POS_LAST = POS_W'(BLOCK_BYTES - 1);
   localparam logic [DATA_W-1:0] PAD_MAX  = DATA_W'(BLOCK_BYTES);

   logic [COUNT_BITS-1:0] count_ff, count_in, count_upd;
   logic [COUNT_BITS-1:0] nzend_ff, nzend_in, nzend_upd;
   logic [DATA_W-1:0]     last_nz_ff, last_nz_in, last_nz_upd;
   logic [DATA_W-1:0]     prev_ff, prev_in;
   logic [RUN_W-1:0]      eq_run_ff, eq_run_in, eq_run_upd;
   logic [RUN_W-1:0]      zero_run_ff, zero_run_in, zero_run_upd;
   logic [POS_W-1:0]      pos_ff, pos_in, pos_upd;

   logic                  nonzero;
   logic                  first;
   logic                  length_bad;
   logic                  pad_ok;
   logic [DATA_W-1:0]     pad_m1;
   logic [COUNT_BITS-1:0] len_pad;
   logic [COUNT_BITS-1:0] len_iso;
   logic                  iso_bad;

   function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] r);
      return (r >= RUN_MAX) ? RUN_MAX : r + 1'b1;
   endfunction

   always_comb begin
      nonzero      = (data_byte != '0);
      first        = (count_ff == '0);
      count_upd    = (count_ff == '1) ? count_ff : count_ff + 1'b1;
      nzend_upd    = nonzero ? count_upd : nzend_ff;
      last_nz_upd  = nonzero ? data_byte : last_nz_ff;
      zero_run_upd = nonzero ? '0 : run_inc(zero_run_ff);
      eq_run_upd   = (first || data_byte != prev_ff) ? RUN_W'(1) : run_inc(eq_run_ff);
      pos_upd      = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;

      if (step && final_byte) begin
         count_in    = '0;
         nzend_in    = '0;
         last_nz_in  = '0;
         prev_in     = '0;
         eq_run_in   = '0;
         zero_run_in = '0;
         pos_in      = '0;
      end else if (step) begin
         count_in    = count_upd;
         nzend_in    = nzend_upd;
         last_nz_in  = last_nz_upd;
         prev_in     = data_byte;
         eq_run_in   = eq_run_upd;
         zero_run_in = zero_run_upd;
         pos_in      = pos_upd;
      end else begin
         count_in    = count_ff;
         nzend_in    = nzend_ff;
         last_nz_in  = last_nz_ff;
         prev_in     = prev_ff;
         eq_run_in   = eq_run_ff;
         zero_run_in = zero_run_ff;
         pos_in      = pos_ff;
      end
   end

   // A count that reaches all ones after this byte is saturated and fails.
   always_comb begin
      length_bad = (&count_ff[COUNT_BITS-1:1]) || (pos_upd != '0);
      pad_ok     = nonzero && (data_byte <= PAD_MAX);
      pad_m1     = data_byte - 1'b1;
      len_pad    = count_ff - COUNT_BITS'(pad_m1);
      len_iso    = nonzero ? count_ff : nzend_ff - 1'b1;
      iso_bad    = (nzend_upd == '0) || (last_nz_upd != ISO_MARK) ||
                   (zero_run_upd >= RUN_MAX);

      result.message_length = '0;
      result.status         = STATUS_BAD;
      if (!length_bad) begin
         unique case (pad_mode)
            MODE_PKCS7: begin
               if (pad_ok && (DATA_W'(eq_run_upd) >= data_byte)) begin
                  result.message_length = LEN_W'(len_pad);
                  result.status         = STATUS_OK;
               end
            end
            MODE_ANSI: begin
               if (pad_ok && (DATA_W'(zero_run_ff) >= pad_m1)) begin
                  result.message_length = LEN_W'(len_pad);
                  result.status         = STATUS_OK;
               end
            end
            MODE_ISO: begin
               if (!iso_bad) begin
                  result.message_length = LEN_W'(len_iso);
                  result.status         = STATUS_OK;
               end
            end
            MODE_ZERO: begin
               result.message_length = LEN_W'(nzend_upd);
               result.status         = STATUS_OK;
            end
            MODE_NONE: begin
               result.message_length = LEN_W'(count_upd);
               result.status         = STATUS_OK;
            end
            default: begin
               result.status = STATUS_UNSUP;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         nzend_ff    <= '0;
         last_nz_ff  <= '0;
         prev_ff     <= '0;
         eq_run_ff   <= '0;
         zero_run_ff <= '0;
         pos_ff      <= '0;
      end else begin
         count_ff    <= count_in;
         nzend_ff    <= nzend_in;
         last_nz_ff  <= last_nz_in;
         prev_ff     <= prev_in;
         eq_run_ff   <= eq_run_in;
         zero_run_ff <= zero_run_in;
         pos_ff      <= pos_in;
      end
   end

endmodule

@@ hdl/bcu_checker.sv @@
// Port-level assertions for the block cipher unpad checker and their binding.
module bcu_checker
   import bcu_pkg::*;
   (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [LEN_W-1:0] rsp_message_length,
   input status_type       rsp_status
);

   // A failed message never reports a length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_message_length == '0)
      else $error("Nonzero length reported with an error status.");

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result offered right after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result withdrawn before its transfer.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_message_length) && $stable(rsp_status))
      else $error("Result changed while stalled.");

endmodule

bind block_cipher_unpad_checker bcu_checker u_bcu_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_port.valid),
   .rsp_ready          (rsp_port.ready),
   .rsp_message_length (rsp_port.message_length),
   .rsp_status         (rsp_port.status)
);
